@@ rtl/i2c_tsrm_pkg.sv @@
// Shared types, codes and constants for the I2C target sensor register map.
`default_nettype none

package i2c_tsrm_pkg;

   localparam int WRITE_DEPTH    = 5;
   localparam int NUM_PORTS      = 4;
   localparam int NUM_SENSORS    = 8;
   localparam int WINDOW_BYTES   = 16;
   localparam int WCOUNT_WIDTH   = $clog2(WRITE_DEPTH + 1);
   localparam int WIDX_WIDTH     = $clog2(WRITE_DEPTH);
   localparam int RPOS_WIDTH     = $clog2(WINDOW_BYTES) + 1;
   localparam int SIDX_WIDTH     = $clog2(NUM_SENSORS);
   localparam int PORT_WIDTH     = $clog2(NUM_PORTS);
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [6:0] RESET_ADDRESS = 7'h69;

   // Command byte ranges decoded on stop.
   localparam logic [7:0] CMD_SETPOINT_LIMIT = 8'd4;
   localparam logic [7:0] CMD_ENABLE_LIMIT   = 8'd8;
   localparam logic [7:0] CMD_GAIN_LIMIT     = 8'd12;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_OWN_ADDRESS = 3'h0;

   typedef enum logic [2:0] {
      OP_SENSOR_UPDATE = 3'd0,
      OP_ADDR_MATCH    = 3'd1,
      OP_MASTER_READ   = 3'd2,
      OP_MASTER_WRITE  = 3'd3,
      OP_STOP          = 3'd4,
      OP_COLLISION     = 3'd5,
      OP_BUS_ERROR     = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      RESP_NONE     = 2'd0,
      RESP_ACK      = 2'd1,
      RESP_COMPLETE = 2'd2,
      RESP_RELEASE  = 2'd3
   } response_type;

   typedef enum logic [1:0] {
      KIND_NONE     = 2'd0,
      KIND_SETPOINT = 2'd1,
      KIND_ENABLE   = 2'd2,
      KIND_GAIN     = 2'd3
   } kind_type;

   typedef struct packed {
      logic [2:0]  op;
      logic        rx_nack;
      logic [7:0]  data_in;
      logic [2:0]  sensor_index;
      logic [15:0] sensor_value;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic [1:0]  response;
      logic [1:0]  update_kind;
      logic [1:0]  update_port;
      logic [15:0] update_value;
      logic        read_overrun;
      logic        write_overrun;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/i2c_target_sensor_register_map_core.sv @@
// Top level of the I2C target sensor register map: request and result registers.
// A request passes the request register, the decode and the result register.
// Throughput: one request per cycle unless the result stalls; the decode sits
// between request and result registers; the result register frees as it is taken.
// Reset is synchronous and active high; it clears the sensor table, buffers,
// counters and settings, sets the first-byte flag and loads address 0x69.
`default_nettype none

module i2c_target_sensor_register_map_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire i2c_tsrm_pkg::req_type                  req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output i2c_tsrm_pkg::rsp_type                       rsp_data,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [i2c_tsrm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [i2c_tsrm_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [i2c_tsrm_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                        csr_pready
);
   import i2c_tsrm_pkg::*;

   logic    req_valid_ff;
   logic    req_valid_in;
   req_type req_data_ff;
   req_type req_data_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   rsp_type result;
   logic    advance;
   logic    step;
   logic [6:0] own_address;

   i2c_tsrm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .own_address (own_address)
   );

   i2c_tsrm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (req_data_ff),
      .own_address (own_address),
      .result      (result)
   );

   // The result register can take a new entry when empty or being drained.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
         req_data_in  = req_data;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/i2c_tsrm_csr.sv @@
// Configuration register block: holds the target's own bus address.
`default_nettype none

module i2c_tsrm_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [i2c_tsrm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [i2c_tsrm_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [i2c_tsrm_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                        csr_pready,
   output logic      [6:0]                             own_address
);
   import i2c_tsrm_pkg::*;

   logic [6:0] own_address_ff;
   logic [6:0] own_address_in;
   logic       sel_own;

   // Registers are word aligned; the two low address bits are ignored.
   assign sel_own = (csr_paddr[CSR_ADDR_WIDTH-1:2] == CSR_OWN_ADDRESS[CSR_ADDR_WIDTH-1:2]);

   always_comb begin
      own_address_in = own_address_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_own) begin
         own_address_in = csr_pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= RESET_ADDRESS;
      end else begin
         own_address_ff <= own_address_in;
      end
   end

   assign csr_prdata  = sel_own ? {{(CSR_DATA_WIDTH-7){1'b0}}, own_address_ff}
                                : '0;
   assign csr_pready  = 1'b1;
   assign own_address = own_address_ff;

endmodule

`default_nettype wire

@@ rtl/i2c_tsrm_core.sv @@
// Register map state and the single-pass event decode that forms each result.
`default_nettype none

module i2c_tsrm_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire i2c_tsrm_pkg::req_type item,
   input  wire logic [6:0]            own_address,
   output i2c_tsrm_pkg::rsp_type      result
);
   import i2c_tsrm_pkg::*;

   logic [15:0]             sensor_ff    [NUM_SENSORS];
   logic [15:0]             sensor_in    [NUM_SENSORS];
   logic [7:0]              wbuf_ff      [WRITE_DEPTH];
   logic [7:0]              wbuf_in      [WRITE_DEPTH];
   logic [15:0]             setpoint_ff  [NUM_PORTS];
   logic [15:0]             setpoint_in  [NUM_PORTS];
   logic [15:0]             gain_ff      [NUM_PORTS];
   logic [15:0]             gain_in      [NUM_PORTS];
   logic [NUM_PORTS-1:0]    enable_ff;
   logic [NUM_PORTS-1:0]    enable_in;
   logic [RPOS_WIDTH-1:0]   rpos_ff;
   logic [RPOS_WIDTH-1:0]   rpos_in;
   logic [WCOUNT_WIDTH-1:0] wcount_ff;
   logic [WCOUNT_WIDTH-1:0] wcount_in;
   logic                    first_ff;
   logic                    first_in;

   logic [15:0]           read_word;
   logic [7:0]            cmd;
   logic [PORT_WIDTH-1:0] port;
   logic [15:0]           word;
   logic                  in_window;
   logic                  buf_full;

   assign read_word = sensor_ff[rpos_ff[SIDX_WIDTH:1]];
   assign in_window = (rpos_ff < RPOS_WIDTH'(WINDOW_BYTES));
   assign buf_full  = (wcount_ff >= WCOUNT_WIDTH'(WRITE_DEPTH));
   assign cmd       = wbuf_ff[0];
   assign port      = cmd[PORT_WIDTH-1:0];
   assign word      = {wbuf_ff[1], wbuf_ff[2]};

   always_comb begin
      sensor_in   = sensor_ff;
      wbuf_in     = wbuf_ff;
      setpoint_in = setpoint_ff;
      gain_in     = gain_ff;
      enable_in   = enable_ff;
      rpos_in     = rpos_ff;
      wcount_in   = wcount_ff;
      first_in    = first_ff;
      result      = '0;

      unique case (op_type'(item.op))
         OP_SENSOR_UPDATE: begin
            sensor_in[item.sensor_index] = item.sensor_value;
         end
         OP_ADDR_MATCH: begin
            result.tx_valid = 1'b1;
            result.tx_byte  = {1'b0, own_address};
            result.response = RESP_ACK;
            first_in        = 1'b1;
         end
         OP_MASTER_READ: begin
            // A NACK on the very first byte still gets data; later it ends the read.
            if (!item.rx_nack || first_ff) begin
               first_in        = 1'b0;
               result.response = RESP_ACK;
               if (in_window) begin
                  result.tx_valid = 1'b1;
                  result.tx_byte  = rpos_ff[0] ? read_word[7:0] : read_word[15:8];
                  rpos_in         = rpos_ff + RPOS_WIDTH'(1);
               end else begin
                  result.read_overrun = 1'b1;
               end
            end else begin
               result.response = RESP_RELEASE;
            end
         end
         OP_MASTER_WRITE: begin
            result.response = RESP_ACK;
            if (!buf_full) begin
               wbuf_in[wcount_ff[WIDX_WIDTH-1:0]] = item.data_in;
               wcount_in = wcount_ff + WCOUNT_WIDTH'(1);
            end else begin
               result.write_overrun = 1'b1;
            end
         end
         OP_STOP: begin
            result.response = RESP_COMPLETE;
            // Entries not rewritten since an earlier command are decoded as they stand.
            if (wcount_ff != '0) begin
               if (cmd < CMD_SETPOINT_LIMIT) begin
                  setpoint_in[port]   = word;
                  result.update_kind  = KIND_SETPOINT;
                  result.update_port  = port;
                  result.update_value = word;
               end else if (cmd < CMD_ENABLE_LIMIT) begin
                  enable_in[port]     = (wbuf_ff[1] != 8'd0);
                  result.update_kind  = KIND_ENABLE;
                  result.update_port  = port;
                  result.update_value = {15'd0, (wbuf_ff[1] != 8'd0)};
               end else if (cmd < CMD_GAIN_LIMIT) begin
                  gain_in[port]       = word;
                  result.update_kind  = KIND_GAIN;
                  result.update_port  = port;
                  result.update_value = word;
               end
            end
            wcount_in = '0;
            rpos_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_ff   <= '{default: '0};
         wbuf_ff     <= '{default: '0};
         setpoint_ff <= '{default: '0};
         gain_ff     <= '{default: '0};
         enable_ff   <= '0;
         rpos_ff     <= '0;
         wcount_ff   <= '0;
         first_ff    <= 1'b1;
      end else if (step) begin
         sensor_ff   <= sensor_in;
         wbuf_ff     <= wbuf_in;
         setpoint_ff <= setpoint_in;
         gain_ff     <= gain_in;
         enable_ff   <= enable_in;
         rpos_ff     <= rpos_in;
         wcount_ff   <= wcount_in;
         first_ff    <= first_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/i2c_tsrm_checker.sv @@
// Port-level checks for the I2C target sensor register map, bound to the top level.
`default_nettype none

module i2c_tsrm_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire i2c_tsrm_pkg::rsp_type rsp_data,
   input wire logic                  csr_pready
);
   import i2c_tsrm_pkg::*;

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_no_stray_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.tx_valid |-> rsp_data.tx_byte == 8'd0)
      else $error("tx_byte nonzero without tx_valid");

   // Settings change only on a stop.
   a_update_on_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.update_kind != KIND_NONE |-> rsp_data.response == RESP_COMPLETE)
      else $error("setting update outside a stop");

   a_overrun_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_overrun |->
         !rsp_data.tx_valid && rsp_data.response == RESP_ACK && !rsp_data.write_overrun)
      else $error("read overrun with data or wrong response");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("configuration port not ready");

endmodule

bind i2c_target_sensor_register_map_core i2c_tsrm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);

`default_nettype wire
